// ===== rtl/core/lsdrs_pkg.sv =====
// Shared constants and helpers for the LSD radix sorter.
// No dependencies; every other file of the sorter except lsdrs_ram refers to this package.
package lsdrs_pkg;

  localparam int KEY_W         = 10;  // key field width
  localparam int DEF_DIGITS    = 3;   // default digits per key
  localparam int DEF_RADIX     = 10;  // default number of buckets
  localparam int DEF_MAX_ITEMS = 32;  // default store depth
  localparam int DIV_SHIFT     = 16;  // fraction bits of the reciprocal divider

  // Largest key that fits in the given digits, capped at the field limit.
  function automatic int key_limit(input int digits, input int radix);
    int p;
    int lim;
    p   = 1;
    lim = -1;
    for (int i = 0; i < digits; i++) begin
      p = p * radix;
      if (p > (1 << KEY_W) && lim < 0) begin
        lim = (1 << KEY_W) - 1;
      end
    end
    if (lim < 0) begin
      lim = p - 1;
    end
    return lim;
  endfunction

endpackage

// ===== rtl/core/lsdrs_in_if.sv =====
// Key input channel of the LSD radix sorter: valid/ready plus one key item.
// Depends on lsdrs_pkg for the key width.
interface lsdrs_in_if;
  logic                        valid;
  logic                        ready;
  logic [lsdrs_pkg::KEY_W-1:0] key_value;
  logic                        end_of_set;

  modport source (output valid, output key_value, output end_of_set, input ready);
  modport sink   (input valid, input key_value, input end_of_set, output ready);
endinterface

// ===== rtl/core/lsdrs_out_if.sv =====
// Result channel of the LSD radix sorter: valid/ready plus one sorted item.
// Depends on lsdrs_pkg for the key width.
interface lsdrs_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsdrs_pkg::KEY_W-1:0] sorted_value;
  logic                        final_flag;
  logic                        dropped;

  modport source (output valid, output sorted_value, output final_flag, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_flag, input dropped,
                  output ready);
endinterface

// ===== rtl/core/lsdrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsdrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/lsdrs_digit_unit.sv =====
// Shared divide-by-radix unit: quotient and remainder of a key.
// Stage one registers the reciprocal product; stage two corrects it. Uses lsdrs_pkg.
module lsdrs_digit_unit #(
  parameter int RADIX = lsdrs_pkg::DEF_RADIX
) (
  input  logic                        clk,
  input  logic [lsdrs_pkg::KEY_W-1:0] x,      // hold stable for two cycles
  output logic [lsdrs_pkg::KEY_W-1:0] q,
  output logic [$clog2(RADIX)-1:0]    rem
);

  localparam int KW     = lsdrs_pkg::KEY_W;
  localparam int SH     = lsdrs_pkg::DIV_SHIFT;
  localparam int DW     = $clog2(RADIX);
  localparam int RW     = $clog2(RADIX) + 1;
  localparam int QW     = KW + RW;
  localparam int PROD_W = KW + SH;
  localparam int RECIP  = (1 << SH) / RADIX;

  localparam logic [PROD_W-1:0] RECIP_V = PROD_W'(RECIP);
  localparam logic [QW-1:0]     RADIX_Q = QW'(RADIX);
  localparam logic [RW-1:0]     RADIX_R = RW'(RADIX);

  logic [PROD_W-1:0] prod_r;
  logic [KW-1:0]     q_est;
  logic [QW-1:0]     q_mul;
  logic [QW-1:0]     diff;
  logic [RW-1:0]     rem_raw;
  logic [RW-1:0]     rem_fix;
  logic              over;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(x) * RECIP_V;
  end

  // estimate is exact or one short; one compare and subtract fixes it
  always_comb begin
    q_est   = prod_r[SH +: KW];
    q_mul   = QW'(q_est) * RADIX_Q;
    diff    = QW'(x) - q_mul;
    rem_raw = diff[RW-1:0];
    over    = (rem_raw >= RADIX_R);
    rem_fix = over ? (rem_raw - RADIX_R) : rem_raw;
    q       = over ? (q_est + KW'(1)) : q_est;
    rem     = rem_fix[DW-1:0];
  end

endmodule

// ===== rtl/core/lsd_decimal_radix_sorter_unit.sv =====
// LSD radix sorter, top level.
// Uses lsdrs_pkg, lsdrs_in_if, lsdrs_out_if, lsdrs_ram and lsdrs_digit_unit.
//
// Usage: keys enter on in_ch one item at a time; the item with end_of_set high
// closes the set (its key belongs to the set). Keys above RADIX^DIGITS-1 are
// clamped. Once the store holds MAX_ITEMS keys, further keys are dropped and
// every result of that set carries dropped = 1.
// Loading: each stored key is split into its digits by the shared
// divide-by-radix unit, through states CV1 and CV2 for each digit;
// in_ch.ready is low meanwhile.
// Sorting: DIGITS stable counting passes between two RAMs; each pass runs
// clear, count scan, prefix sum and scatter for the n held keys, paced by the
// single read port of the source RAM.
// Output: results leave sorted through an output register on out_ch, with one
// read in flight at a time; final_flag marks the last. A stall on out_ch holds the
// item and pauses the read-out.
// Reset: synchronous, active low; clears the set state, input ready after it.
module lsd_decimal_radix_sorter_unit #(
  parameter int DIGITS    = lsdrs_pkg::DEF_DIGITS,
  parameter int RADIX     = lsdrs_pkg::DEF_RADIX,
  parameter int MAX_ITEMS = lsdrs_pkg::DEF_MAX_ITEMS
) (
  input  logic  clk,
  input  logic  rst_n,
  lsdrs_in_if.sink    in_ch,
  lsdrs_out_if.source out_ch
);

  localparam int KW     = lsdrs_pkg::KEY_W;
  localparam int DW     = $clog2(RADIX);
  localparam int PW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNTW   = $clog2(MAX_ITEMS + 1);
  localparam int AW     = $clog2(MAX_ITEMS);
  localparam int WORD_W = DIGITS * DW + KW;
  localparam int KEY_LIMIT = lsdrs_pkg::key_limit(DIGITS, RADIX);

  localparam logic [KW-1:0]   KEY_LIM_V = KW'(KEY_LIMIT);
  localparam logic [CNTW-1:0] FULL_V    = CNTW'(MAX_ITEMS);
  localparam logic [PW-1:0]   LAST_PASS = PW'(DIGITS - 1);
  localparam logic [DW-1:0]   LAST_BKT  = DW'(RADIX - 1);

  // sequencer states
  localparam logic [2:0] ST_LOAD = 3'd0;  // take keys
  localparam logic [2:0] ST_CV1  = 3'd1;  // divider multiply
  localparam logic [2:0] ST_CV2  = 3'd2;  // divider correct, shift digit in
  localparam logic [2:0] ST_CLR  = 3'd3;  // clear bucket counters
  localparam logic [2:0] ST_CNT  = 3'd4;  // count digits of the source
  localparam logic [2:0] ST_PFX  = 3'd5;  // counts to start offsets
  localparam logic [2:0] ST_SCT  = 3'd6;  // scatter into the destination
  localparam logic [2:0] ST_EMIT = 3'd7;  // read out sorted keys

  typedef logic [DIGITS-1:0][DW-1:0] digits_t;

  logic [2:0]          state_r;
  logic [CNTW-1:0]     held_r;
  logic                ovf_r;
  logic                last_r;
  logic [KW-1:0]       x_r;
  logic [KW-1:0]       key_r;
  digits_t             dig_r;
  logic [PW-1:0]       pass_r;
  logic                src_pong_r;
  logic [CNTW-1:0]     idx_r;
  logic                rd_pend_r;
  logic [CNTW-1:0]     cnt_r [RADIX];
  logic [DW-1:0]       bidx_r;
  logic [CNTW-1:0]     run_r;
  logic                out_valid_r;
  logic [KW-1:0]       out_value_r;
  logic                out_final_r;
  logic                out_drop_r;

  logic [KW-1:0]       div_q;
  logic [DW-1:0]       div_rem;
  digits_t             dig_nxt;
  digits_t             rd_digits;
  digits_t             rot_digits;
  logic [WORD_W-1:0]   ping_rd;
  logic [WORD_W-1:0]   pong_rd;
  logic [WORD_W-1:0]   rd_word;
  logic [DW-1:0]       cur_dig;
  logic [DW-1:0]       cnt_sel;
  logic [CNTW-1:0]     cnt_rd;
  logic [KW-1:0]       key_cl;
  logic                in_fire;
  logic                out_free;
  logic                issue;
  logic                scan_done;
  logic                cv_done;
  logic                sct_wr;
  logic                ping_we;
  logic                pong_we;
  logic [AW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_word;

  lsdrs_digit_unit #(.RADIX(RADIX)) u_div (
    .clk (clk),
    .x   (x_r),
    .q   (div_q),
    .rem (div_rem)
  );

  lsdrs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ping (
    .clk     (clk),
    .wr_en   (ping_we),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ping_rd)
  );

  lsdrs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_pong (
    .clk     (clk),
    .wr_en   (pong_we),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (pong_rd)
  );

  assign in_ch.ready         = (state_r == ST_LOAD);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.final_flag   = out_final_r;
  assign out_ch.dropped      = out_drop_r;

  always_comb begin
    in_fire  = in_ch.valid && (state_r == ST_LOAD);
    key_cl   = (in_ch.key_value > KEY_LIM_V) ? KEY_LIM_V : in_ch.key_value;
    out_free = !out_valid_r || out_ch.ready;

    // shift the new remainder in at the top; after DIGITS steps digit 0 sits lowest
    for (int i = 0; i < DIGITS - 1; i++) begin
      dig_nxt[i] = dig_r[i + 1];
    end
    dig_nxt[DIGITS-1] = div_rem;
    cv_done = (state_r == ST_CV2) && (pass_r == LAST_PASS);

    rd_word   = src_pong_r ? pong_rd : ping_rd;
    rd_digits = rd_word[WORD_W-1:KW];
    cur_dig   = rd_digits[0];
    // rotate so the next pass finds its digit lowest again
    for (int i = 0; i < DIGITS - 1; i++) begin
      rot_digits[i] = rd_digits[i + 1];
    end
    rot_digits[DIGITS-1] = rd_digits[0];

    cnt_sel = (state_r == ST_PFX) ? bidx_r : cur_dig;
    cnt_rd  = cnt_r[cnt_sel];

    case (state_r)
      ST_CNT, ST_SCT: issue = (idx_r != held_r);
      ST_EMIT:        issue = (idx_r != held_r) && !rd_pend_r && out_free;
      default:        issue = 1'b0;
    endcase
    scan_done = (idx_r == held_r) && !rd_pend_r;

    sct_wr  = (state_r == ST_SCT) && rd_pend_r;
    ping_we = cv_done || (sct_wr && src_pong_r);
    pong_we = sct_wr && !src_pong_r;
    wr_addr = (state_r == ST_SCT) ? cnt_rd[AW-1:0] : held_r[AW-1:0];
    wr_word = (state_r == ST_SCT) ? {rot_digits, rd_word[KW-1:0]} : {dig_nxt, key_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      held_r      <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      pass_r      <= '0;
      src_pong_r  <= 1'b0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      bidx_r      <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
      for (int b = 0; b < RADIX; b++) begin
        cnt_r[b] <= '0;
      end
    end else begin
      rd_pend_r <= issue;
      if (issue) begin
        idx_r <= idx_r + CNTW'(1);
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (held_r == FULL_V) begin
              // store full: drop the key, flag the set
              ovf_r <= 1'b1;
              if (in_ch.end_of_set) begin
                pass_r     <= '0;
                src_pong_r <= 1'b0;
                state_r    <= ST_CLR;
              end
            end else begin
              x_r     <= key_cl;
              key_r   <= key_cl;
              last_r  <= in_ch.end_of_set;
              pass_r  <= '0;
              state_r <= ST_CV1;
            end
          end
        end
        ST_CV1: begin
          state_r <= ST_CV2;
        end
        ST_CV2: begin
          x_r   <= div_q;
          dig_r <= dig_nxt;
          if (cv_done) begin
            held_r     <= held_r + CNTW'(1);
            pass_r     <= '0;
            src_pong_r <= 1'b0;
            state_r    <= last_r ? ST_CLR : ST_LOAD;
          end else begin
            pass_r  <= pass_r + PW'(1);
            state_r <= ST_CV1;
          end
        end
        ST_CLR: begin
          for (int b = 0; b < RADIX; b++) begin
            cnt_r[b] <= '0;
          end
          idx_r   <= '0;
          bidx_r  <= '0;
          run_r   <= '0;
          state_r <= ST_CNT;
        end
        ST_CNT: begin
          if (rd_pend_r) begin
            cnt_r[cnt_sel] <= cnt_rd + CNTW'(1);
          end
          if (scan_done) begin
            state_r <= ST_PFX;
          end
        end
        ST_PFX: begin
          // exclusive prefix sum, one bucket a cycle
          cnt_r[cnt_sel] <= run_r;
          run_r          <= run_r + cnt_rd;
          bidx_r         <= bidx_r + DW'(1);
          if (bidx_r == LAST_BKT) begin
            idx_r   <= '0;
            state_r <= ST_SCT;
          end
        end
        ST_SCT: begin
          if (rd_pend_r) begin
            cnt_r[cnt_sel] <= cnt_rd + CNTW'(1);
          end
          if (scan_done) begin
            src_pong_r <= !src_pong_r;
            idx_r      <= '0;
            if (pass_r == LAST_PASS) begin
              state_r <= ST_EMIT;
            end else begin
              pass_r  <= pass_r + PW'(1);
              state_r <= ST_CLR;
            end
          end
        end
        ST_EMIT: begin
          // read issued only when the output register is free next cycle
          if (rd_pend_r) begin
            out_valid_r <= 1'b1;
            out_value_r <= rd_word[KW-1:0];
            out_final_r <= (idx_r == held_r);
            out_drop_r  <= ovf_r;
          end
          if (scan_done) begin
            held_r  <= '0;
            ovf_r   <= 1'b0;
            pass_r  <= '0;
            state_r <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lsd_decimal_radix_sorter_unit: random and directed key sets
// are checked against a behavioral radix sort. Depends on lsdrs_pkg and the sorter RTL.
module testbench;

  typedef logic [lsdrs_pkg::KEY_W-1:0] key_t;
  typedef key_t key_queue_t[$];

  typedef struct packed {
    key_t sorted_value;
    logic final_flag;
    logic dropped;
  } sorted_item_t;

  localparam int TOTAL_KEYS   = 450;  // rough size of the whole stimulus
  localparam int MAX_GAP      = 18;   // longest idle stretch per item, either side
  localparam int DRAIN_CYCLES = 500;  // idle wait after the last expected item, to catch strays

  // Tracks the keys of the open set, sorts them when the set closes and holds
  // the ordered items until the block hands them out.
  class sort_tracker;
    key_t         held_keys[$];
    bit           keys_lost;
    sorted_item_t pending_sorted[$];
    key_t         key_ceiling;
    int           errors;
    int           sets_closed;
    int           keys_accepted;
    int           items_checked;
    int           overflow_sets;
    int           clamped_keys;

    function new();
      longint span;
      span = 1;
      for (int d = 0; d < lsdrs_pkg::DEF_DIGITS; d++) begin
        span = span * lsdrs_pkg::DEF_RADIX;
      end
      // Clamp to the largest key the digits hold, never past the field width.
      key_ceiling = (span > (longint'(1) << lsdrs_pkg::KEY_W)) ?
                    {lsdrs_pkg::KEY_W{1'b1}} : key_t'(span - 1);
    endfunction

    // Stable counting sort per digit, lowest digit first.
    function key_queue_t radix_order(key_queue_t keys);
      key_queue_t src;
      key_queue_t dst;
      int         tally[lsdrs_pkg::DEF_RADIX];
      int         slot[lsdrs_pkg::DEF_RADIX];
      int         weight;
      int         run;
      int         digit;
      src    = keys;
      weight = 1;
      for (int pass = 0; pass < lsdrs_pkg::DEF_DIGITS; pass++) begin
        foreach (tally[b]) tally[b] = 0;
        foreach (src[i]) tally[(int'(src[i]) / weight) % lsdrs_pkg::DEF_RADIX]++;
        run = 0;
        for (int b = 0; b < lsdrs_pkg::DEF_RADIX; b++) begin
          slot[b] = run;
          run    += tally[b];
        end
        dst = src;
        foreach (src[i]) begin
          digit           = (int'(src[i]) / weight) % lsdrs_pkg::DEF_RADIX;
          dst[slot[digit]] = src[i];
          slot[digit]++;
        end
        src    = dst;
        weight = weight * lsdrs_pkg::DEF_RADIX;
      end
      return src;
    endfunction

    function void note_key(key_t raw_key, logic is_last);
      key_t       key;
      key_queue_t order;
      sorted_item_t item;
      keys_accepted++;
      key = raw_key;
      if (raw_key > key_ceiling) begin
        key = key_ceiling;
        clamped_keys++;
      end
      // Drop keys once the store is full; the whole set gets flagged.
      if (held_keys.size() < lsdrs_pkg::DEF_MAX_ITEMS) held_keys.push_back(key);
      else keys_lost = 1'b1;
      if (!is_last) return;
      order = radix_order(held_keys);
      foreach (order[i]) begin
        item.sorted_value = order[i];
        item.final_flag   = (i == order.size() - 1);
        item.dropped      = keys_lost;
        pending_sorted.push_back(item);
      end
      sets_closed++;
      if (keys_lost) overflow_sets++;
      held_keys.delete();
      keys_lost = 1'b0;
    endfunction

    function void check_result(key_t value, logic is_last, logic drop);
      sorted_item_t want;
      if (pending_sorted.size() == 0) begin
        $error("unexpected sorted item: sorted_value %0d final_flag %0b dropped %0b",
               value, is_last, drop);
        errors++;
        return;
      end
      want = pending_sorted.pop_front();
      items_checked++;
      if (value !== want.sorted_value) begin
        $error("sorted_value mismatch: expected %0d, actual %0d", want.sorted_value, value);
        errors++;
      end
      if (is_last !== want.final_flag) begin
        $error("final_flag mismatch: expected %0b, actual %0b", want.final_flag, is_last);
        errors++;
      end
      if (drop !== want.dropped) begin
        $error("dropped mismatch: expected %0b, actual %0b", want.dropped, drop);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lsdrs_in_if  in_ch();
  lsdrs_out_if out_ch();

  lsd_decimal_radix_sorter_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sort_tracker tracker = new();

  int  keys_sent;
  int  src_run_left;
  bit  src_no_idle;
  int  sink_run_left;
  bit  sink_no_idle;

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle pattern: stretches of items either with random gaps or back to back,
  // so that stalls land on every phase of loading, sorting and read-out.
  function automatic int next_gap(inout int run_left, inout bit no_idle);
    if (run_left == 0) begin
      run_left = $urandom_range(4, 40);
      no_idle  = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Mostly full-range keys (every bit toggles), a tenth at the top of the field to get
  // clamped, some from a narrow pool to force duplicates and crowded buckets.
  function automatic key_t random_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return key_t'($urandom_range(0, (1 << lsdrs_pkg::KEY_W) - 1));
    if (pick < 8) return key_t'($urandom_range(0, 4) * 101);
    if (pick < 9) return key_t'($urandom_range(995, (1 << lsdrs_pkg::KEY_W) - 1));
    return key_t'($urandom_range(0, 9));
  endfunction

  // Present one key and hold it until the block takes it. Valid stays high
  // into the next item when no gap is drawn.
  task automatic send_key(input key_t key, input logic is_last);
    int gap;
    gap = next_gap(src_run_left, src_no_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key_value  <= key;
    in_ch.end_of_set <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    keys_sent++;
  endtask

  task automatic send_set(input key_queue_t keys);
    foreach (keys[i]) send_key(keys[i], i == keys.size() - 1);
  endtask

  task automatic send_random_set(input int set_size);
    key_queue_t keys;
    repeat (set_size) keys.push_back(random_key());
    send_set(keys);
  endtask

  // Observe both channels at the clock edge; values are those from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_key(in_ch.key_value, in_ch.end_of_set);
      end
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_result(out_ch.sorted_value, out_ch.final_flag, out_ch.dropped);
      end
    end
  end

  // Result side: drop ready for a drawn number of cycles, then hold it until
  // an item is taken.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = next_gap(sink_run_left, sink_no_idle);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Main sequence.
  initial begin
    int size_pick;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.key_value  <= '0;
    in_ch.end_of_set <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a lone key, the field extremes with clamping, keys that share
    // digits in different places, and a run of equal keys.
    send_set('{key_t'(0)});
    send_set('{key_t'(1023), key_t'(1000), key_t'(999), key_t'(0), key_t'(512)});
    send_set('{key_t'(305), key_t'(35), key_t'(350), key_t'(305), key_t'(53),
               key_t'(530), key_t'(3), key_t'(999)});
    send_set('{key_t'(7), key_t'(7), key_t'(7)});

    // Fill the store exactly, then overflow it by one so the closing key is
    // the one dropped.
    send_random_set(lsdrs_pkg::DEF_MAX_ITEMS);
    send_random_set(lsdrs_pkg::DEF_MAX_ITEMS + 1);

    // Random sets, mostly small, a few full or overflowing.
    while (keys_sent < TOTAL_KEYS) begin
      size_pick = $urandom_range(0, 99);
      if (size_pick < 60)      send_random_set($urandom_range(1, 8));
      else if (size_pick < 85) send_random_set($urandom_range(9, 24));
      else if (size_pick < 95) send_random_set($urandom_range(25, lsdrs_pkg::DEF_MAX_ITEMS));
      else send_random_set($urandom_range(lsdrs_pkg::DEF_MAX_ITEMS + 1,
                                          lsdrs_pkg::DEF_MAX_ITEMS + 8));
    end
    in_ch.valid <= 1'b0;

    // Drain: wait out every expected item, then watch for strays.
    @(posedge clk);
    while (tracker.pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d keys in %0d sets (%0d clamped, %0d sets with dropped keys),",
             tracker.keys_accepted, tracker.sets_closed, tracker.clamped_keys,
             tracker.overflow_sets);
    $display("and %0d sorted items checked, %0d mismatches.",
             tracker.items_checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("PASS lsd_decimal_radix_sorter_unit");
    end else begin
      $display("FAIL lsd_decimal_radix_sorter_unit");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run.
  initial begin
    #10ms;
    $display("FAIL lsd_decimal_radix_sorter_unit");
    $finish;
  end

endmodule
